[rtl/tmcw_pkg.sv]
// Shared types, field widths and character codes for the text-mode console writer.
package tmcw_pkg;

   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int COLOR_W  = 4;
   localparam int ADDR_W   = 11;
   localparam int LOC_W    = 11;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int CELL_W   = 16;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [COLOR_W-1:0]  color_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [CELL_W-1:0]   cell_type;
   typedef logic [7:0]          attr_type;

   localparam opcode_type OP_PUT   = 2'd0;
   localparam opcode_type OP_CLEAR = 2'd1;
   localparam opcode_type OP_READ  = 2'd2;

   localparam char_type CH_BS    = 8'h08;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_LF    = 8'h0A;
   localparam char_type CH_CR    = 8'h0D;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_DEL   = 8'h7F;

   localparam cell_type BLANK_CELL = 16'h0F20;

endpackage

[rtl/tmcw_screen_ram.sv]
// Screen cell memory with one write port and one registered read port.
module tmcw_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  tmcw_pkg::cell_type       wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output tmcw_pkg::cell_type       rd_data
);
   import tmcw_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tmcw_cursor.sv]
// Next-cursor logic for a put command: control codes, printable store, wrap and scroll test.
module tmcw_cursor #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8,
   parameter int CW        = 7,
   parameter int RW        = 5,
   parameter int PW        = 3,
   parameter int AW        = 11
) (
   input  logic [CW-1:0]          col_i,
   input  logic [RW-1:0]          row_i,
   input  logic [PW-1:0]          phase_i,
   input  tmcw_pkg::char_type     char_code,
   input  tmcw_pkg::attr_type     attr,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output tmcw_pkg::cell_type     wr_data,
   output logic [CW-1:0]          col_o,
   output logic [RW-1:0]          row_o,
   output logic [PW-1:0]          phase_o,
   output logic                   scroll_o
);
   import tmcw_pkg::*;

   localparam int TW = $clog2(COLUMNS + TAB_WIDTH + 1);
   localparam logic [TW-1:0] COLS_T   = TW'(COLUMNS);
   localparam logic [TW-1:0] TAB_T    = TW'(TAB_WIDTH);
   localparam logic [PW-1:0] PH_LAST  = PW'(TAB_WIDTH - 1);
   localparam logic [RW:0]   ROWS_R   = (RW+1)'(ROWS);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
   localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

   logic [TW-1:0] col_t;
   logic [RW:0]   row_t;
   logic [PW-1:0] phase_t;
   logic [CW-1:0] wr_col;
   logic [PW-1:0] phase_up;
   logic [PW-1:0] phase_down;

   always_comb begin
      phase_up   = (phase_i == PH_LAST) ? '0 : phase_i + 1'b1;
      phase_down = (phase_i == '0) ? PH_LAST : phase_i - 1'b1;
      col_t      = TW'(col_i);
      row_t      = (RW+1)'(row_i);
      phase_t    = phase_i;
      wr_en      = 1'b0;
      wr_col     = col_i;
      wr_data    = {attr, char_code};
      if (char_code == CH_BS) begin
         if (col_i != '0) begin
            wr_en   = 1'b1;
            wr_col  = col_i - 1'b1;
            wr_data = {attr, CH_SPACE};
            col_t   = TW'(col_i - 1'b1);
            phase_t = phase_down;
         end
      end else if (char_code == CH_TAB) begin
         col_t   = TW'(col_i) + TAB_T - TW'(phase_i);
         phase_t = '0;
      end else if (char_code == CH_CR) begin
         col_t   = '0;
         phase_t = '0;
      end else if (char_code inside {[CH_SPACE:CH_DEL]}) begin
         wr_en   = 1'b1;
         col_t   = TW'(col_i) + 1'b1;
         phase_t = phase_up;
      end else if (char_code == CH_LF) begin
         col_t   = '0;
         phase_t = '0;
         row_t   = row_t + 1'b1;
      end
      if (col_t >= COLS_T) begin
         col_t   = '0;
         phase_t = '0;
         row_t   = row_t + 1'b1;
      end
      scroll_o = (row_t >= ROWS_R);
      row_o    = scroll_o ? ROW_LAST : row_t[RW-1:0];
      col_o    = col_t[CW-1:0];
      phase_o  = phase_t;
      wr_addr  = AW'(AW'(row_i) * COLS_A + AW'(wr_col));
   end

endmodule

[rtl/text_mode_console_writer_unit.sv]
// Top level of the text-mode console writer: command sequencer, cursor registers and result register.
//
//   channel | ports                                                                | direction
//   req     | req_valid/req_ready, opcode, char_code, colors, cell addr            | in
//   rsp     | rsp_valid/rsp_ready, cursor location/column/row, scrolled, read_data | out
//
// A put that scrolls moves the screen up one cell per cycle through the single write port
// of the screen memory. A new request is taken once the previous command has its result
// loaded, even while that result is still stalled.
// Reset clears the cursor and the control state; the screen holds garbage until cleared.
module text_mode_console_writer_unit #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tmcw_pkg::opcode_type    req_opcode,
   input  tmcw_pkg::char_type      req_char_code,
   input  tmcw_pkg::color_type     req_back_color,
   input  tmcw_pkg::color_type     req_fore_color,
   input  tmcw_pkg::addr_type      req_cell_address,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [10:0]             rsp_cursor_location,
   output logic [6:0]              rsp_cursor_column,
   output logic [4:0]              rsp_cursor_row,
   output logic                    rsp_scrolled,
   output tmcw_pkg::cell_type      rsp_read_data
);
   import tmcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int MOVE  = (ROWS - 1) * COLUMNS;
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int PW    = $clog2(TAB_WIDTH);
   localparam int AW    = $clog2(CELLS);
   localparam int CMPW  = (AW + 1 > ADDR_W) ? AW + 1 : ADDR_W;

   localparam logic [AW:0]     CNT_MOVE = (AW+1)'(MOVE);
   localparam logic [AW:0]     CNT_LAST = (AW+1)'(CELLS - 1);
   localparam logic [AW:0]     CNT_COLS = (AW+1)'(COLUMNS);
   localparam logic [AW-1:0]   COLS_A   = AW'(COLUMNS);
   localparam logic [CMPW-1:0] CELLS_C  = CMPW'(CELLS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [AW:0]   cnt_ff, cnt_in;
   opcode_type    op_ff;
   char_type      char_ff;
   attr_type      attr_ff;
   addr_type      addr_ff;
   logic          scrolled_ff, scrolled_in;
   cell_type      data_ff, data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [10:0]   rsp_loc_ff;
   logic [6:0]    rsp_col_ff;
   logic [4:0]    rsp_row_ff;
   logic          rsp_scr_ff;
   cell_type      rsp_data_ff;

   logic          cur_wr_en;
   logic [AW-1:0] cur_wr_addr;
   cell_type      cur_wr_data;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row;
   logic [PW-1:0] cur_phase;
   logic          cur_scroll;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   cell_type      ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   cell_type      ram_rd_data;

   logic          addr_ok;
   logic          rsp_load;
   logic [AW-1:0] loc_full;

   tmcw_cursor #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH),
      .CW        (CW),
      .RW        (RW),
      .PW        (PW),
      .AW        (AW)
   ) u_cursor (
      .col_i     (col_ff),
      .row_i     (row_ff),
      .phase_i   (phase_ff),
      .char_code (char_ff),
      .attr      (attr_ff),
      .wr_en     (cur_wr_en),
      .wr_addr   (cur_wr_addr),
      .wr_data   (cur_wr_data),
      .col_o     (cur_col),
      .row_o     (cur_row),
      .phase_o   (cur_phase),
      .scroll_o  (cur_scroll)
   );

   tmcw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign addr_ok   = (CMPW'(addr_ff) < CELLS_C);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign loc_full  = AW'(AW'(row_ff) * COLS_A + AW'(col_ff));

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      scrolled_in  = scrolled_ff;
      data_in      = data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_wr_addr;
      ram_wr_data  = cur_wr_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(addr_ff);
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            scrolled_in = 1'b0;
            data_in     = '0;
            state_in    = S_DONE;
            case (op_ff)
               OP_PUT: begin
                  ram_wr_en   = cur_wr_en;
                  col_in      = cur_col;
                  row_in      = cur_row;
                  phase_in    = cur_phase;
                  scrolled_in = cur_scroll;
                  if (cur_scroll) begin
                     cnt_in   = '0;
                     state_in = S_SCROLL;
                  end
               end
               OP_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  phase_in = '0;
                  cnt_in   = '0;
                  state_in = S_FILL;
               end
               OP_READ: begin
                  if (addr_ok) begin
                     ram_rd_en = 1'b1;
                     state_in  = S_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            data_in  = ram_rd_data;
            state_in = S_DONE;
         end
         S_SCROLL: begin
            ram_rd_addr = AW'(cnt_ff + CNT_COLS);
            ram_rd_en   = (cnt_ff < CNT_MOVE);
            ram_wr_en   = (cnt_ff != '0);
            ram_wr_addr = AW'(cnt_ff - 1'b1);
            ram_wr_data = ram_rd_data;
            if (cnt_ff == CNT_MOVE) begin
               state_in = S_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[AW-1:0];
            ram_wr_data = BLANK_CELL;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      scrolled_ff <= scrolled_in;
      data_ff     <= data_in;
      if (req_valid && req_ready) begin
         op_ff   <= req_opcode;
         char_ff <= req_char_code;
         attr_ff <= {req_back_color, req_fore_color};
         addr_ff <= req_cell_address;
      end
      if (rsp_load) begin
         rsp_loc_ff  <= LOC_W'(loc_full);
         rsp_col_ff  <= COL_W'(col_ff);
         rsp_row_ff  <= ROW_W'(row_ff);
         rsp_scr_ff  <= scrolled_ff;
         rsp_data_ff <= data_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_scrolled        = rsp_scr_ff;
   assign rsp_read_data       = rsp_data_ff;

endmodule

[verif/text_mode_console_writer_unit_tb.sv]
// Self-checking testbench for the text-mode console writer with a scoreboard of cursor reports.
module text_mode_console_writer_unit_tb;
   import tmcw_pkg::*;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int TAB_WIDTH   = 8;
   localparam int CELLS       = COLUMNS * ROWS;
   localparam int TOTAL_ITEMS = 1650;
   localparam int CALM_FIRST  = 700;
   localparam int CALM_LAST   = 1000;

   localparam opcode_type OP_UNUSED   = 2'd3;
   localparam char_type   CH_NUL      = 8'h00;
   localparam char_type   CH_UNIT_SEP = 8'h1F;
   localparam char_type   CH_HIGH_LO  = 8'h80;
   localparam char_type   CH_HIGH_HI  = 8'hFF;

   typedef struct packed {
      logic [10:0] location;
      logic [6:0]  column;
      logic [4:0]  row;
      logic        scrolled;
      cell_type    data;
   } cursor_report_type;

   class console_scoreboard;
      cell_type          screen[CELLS];
      int                cur_col;
      int                cur_row;
      cursor_report_type awaited[$];
      int                errors;
      int                checked;
      int                puts;
      int                clears;
      int                reads;
      int                scrolls;

      function void note_command(opcode_type op, char_type ch, color_type bk,
                                 color_type fg, addr_type addr);
         cursor_report_type rep;
         attr_type          attr;
         logic              did_scroll;
         cell_type          data;
         attr = {bk, fg};
         did_scroll = 1'b0;
         data = '0;
         case (op)
            OP_PUT: begin
               puts++;
               if (ch == CH_BS) begin
                  if (cur_col > 0) begin
                     screen[cur_row * COLUMNS + cur_col - 1] = {attr, CH_SPACE};
                     cur_col--;
                  end
               end else if (ch == CH_TAB) begin
                  cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
               end else if (ch == CH_CR) begin
                  cur_col = 0;
               end else if (ch >= CH_SPACE && ch <= CH_DEL) begin
                  screen[cur_row * COLUMNS + cur_col] = {attr, ch};
                  cur_col++;
               end else if (ch == CH_LF) begin
                  cur_col = 0;
                  cur_row++;
               end
               if (cur_col >= COLUMNS) begin
                  cur_col = 0;
                  cur_row++;
               end
               if (cur_row >= ROWS) begin
                  for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                  for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = BLANK_CELL;
                  cur_row = ROWS - 1;
                  did_scroll = 1'b1;
                  scrolls++;
               end
            end
            OP_CLEAR: begin
               clears++;
               for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
               cur_col = 0;
               cur_row = 0;
            end
            OP_READ: begin
               reads++;
               if (addr < CELLS) data = screen[addr];
            end
            default: begin
            end
         endcase
         rep.location = 11'(cur_row * COLUMNS + cur_col);
         rep.column   = 7'(cur_col);
         rep.row      = 5'(cur_row);
         rep.scrolled = did_scroll;
         rep.data     = data;
         awaited.push_back(rep);
      endfunction

      function void check_result(cursor_report_type got);
         cursor_report_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result %h with nothing outstanding", $time, got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.location !== want.location) begin
            $display("%0t: cursor_location expected %0d actual %0d", $time, want.location,
                     got.location);
            errors++;
         end
         if (got.column !== want.column) begin
            $display("%0t: cursor_column expected %0d actual %0d", $time, want.column,
                     got.column);
            errors++;
         end
         if (got.row !== want.row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, got.row);
            errors++;
         end
         if (got.scrolled !== want.scrolled) begin
            $display("%0t: scrolled expected %0d actual %0d", $time, want.scrolled,
                     got.scrolled);
            errors++;
         end
         if (got.data !== want.data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.data, got.data);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   opcode_type req_opcode;
   char_type   req_char_code;
   color_type  req_back_color;
   color_type  req_fore_color;
   addr_type   req_cell_address;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [10:0] rsp_cursor_location;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic        rsp_scrolled;
   cell_type    rsp_read_data;

   console_scoreboard sb = new();
   int  sent = 0;
   logic calm;

   assign calm = (sent >= CALM_FIRST) && (sent < CALM_LAST);

   text_mode_console_writer_unit #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_WIDTH(TAB_WIDTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_char_code      (req_char_code),
      .req_back_color     (req_back_color),
      .req_fore_color     (req_fore_color),
      .req_cell_address   (req_cell_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cursor_location(rsp_cursor_location),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_scrolled       (rsp_scrolled),
      .rsp_read_data      (rsp_read_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result({rsp_cursor_location, rsp_cursor_column, rsp_cursor_row,
                          rsp_scrolled, rsp_read_data});
      end
      rsp_ready <= calm || ($urandom_range(99) >= 20);
   end

   task automatic send_command(opcode_type op, char_type ch, color_type bk, color_type fg,
                               addr_type addr);
      if (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_char_code    <= ch;
      req_back_color   <= bk;
      req_fore_color   <= fg;
      req_cell_address <= addr;
      do @(posedge clock); while (!req_ready);
      sb.note_command(op, ch, bk, fg, addr);
      sent++;
   endtask

   task automatic send_put(char_type ch, color_type bk, color_type fg);
      send_command(OP_PUT, ch, bk, fg, addr_type'($urandom_range(2047)));
   endtask

   task automatic send_read(addr_type addr);
      send_command(OP_READ, char_type'($urandom_range(255)), color_type'($urandom_range(15)),
                   color_type'($urandom_range(15)), addr);
   endtask

   function automatic char_type pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 62) return char_type'($urandom_range(CH_SPACE, CH_DEL));
      if (r < 72) return CH_LF;
      if (r < 76) return CH_CR;
      if (r < 81) return CH_TAB;
      if (r < 87) return CH_BS;
      if (r < 93) return char_type'($urandom_range(CH_HIGH_LO, CH_HIGH_HI));
      return char_type'($urandom_range(CH_NUL, CH_UNIT_SEP));
   endfunction

   initial begin
      int        r;
      int        len;
      color_type bk;
      color_type fg;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= OP_PUT;
      req_char_code    <= CH_NUL;
      req_back_color   <= '0;
      req_fore_color   <= '0;
      req_cell_address <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The screen holds garbage after reset, so it is cleared before anything reads it.
      send_command(OP_CLEAR, CH_NUL, 4'd0, 4'd0, 11'd0);
      send_put(CH_SPACE, 4'd0, 4'd0);
      send_put(CH_DEL, 4'd15, 4'd15);
      send_put(8'h41, 4'd10, 4'd5);
      send_put(CH_HIGH_LO, 4'd3, 4'd4);
      send_put(CH_HIGH_HI, 4'd3, 4'd4);
      send_put(CH_NUL, 4'd3, 4'd4);
      send_put(CH_UNIT_SEP, 4'd3, 4'd4);
      send_put(CH_BS, 4'd6, 4'd9);
      send_put(CH_TAB, 4'd1, 4'd2);
      send_put(CH_TAB, 4'd1, 4'd2);
      send_read(11'd0);
      send_read(11'd1);
      send_read(11'd2);
      send_put(CH_CR, 4'd0, 4'd0);
      send_put(CH_BS, 4'd15, 4'd15);
      send_put(CH_LF, 4'd0, 4'd0);
      send_read(11'd1999);
      send_read(11'd2000);
      send_read(11'd2047);
      send_command(OP_UNUSED, CH_HIGH_HI, 4'd15, 4'd15, 11'd2047);
      send_put(8'h7E, 4'd12, 4'd7);
      send_read(11'd80);

      while (sent < TOTAL_ITEMS) begin
         r = $urandom_range(99);
         if (r < 2) begin
            send_command(OP_CLEAR, char_type'($urandom_range(255)),
                         color_type'($urandom_range(15)), color_type'($urandom_range(15)),
                         addr_type'($urandom_range(2047)));
         end else if (r < 14) begin
            if ($urandom_range(1) == 0) begin
               send_read(addr_type'($urandom_range(2047)));
            end else begin
               send_read(addr_type'(sb.cur_row * COLUMNS + $urandom_range(COLUMNS - 1)));
            end
         end else if (r < 16) begin
            send_command(OP_UNUSED, char_type'($urandom_range(255)),
                         color_type'($urandom_range(15)), color_type'($urandom_range(15)),
                         addr_type'($urandom_range(2047)));
         end else begin
            len = $urandom_range(1, 20);
            bk = color_type'($urandom_range(15));
            fg = color_type'($urandom_range(15));
            repeat (len) begin
               if ($urandom_range(9) == 0) begin
                  bk = color_type'($urandom_range(15));
                  fg = color_type'($urandom_range(15));
               end
               send_put(pick_char(), bk, fg);
            end
         end
      end
      req_valid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (CELLS + 20) @(posedge clock);

      $display("Ran %0d commands: %0d puts, %0d clears, %0d reads, %0d scrolls.",
               sent, sb.puts, sb.clears, sb.reads, sb.scrolls);
      $display("Checked %0d results with %0d field mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("text_mode_console_writer_unit test passed");
      end else begin
         $display("text_mode_console_writer_unit test failed");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("Timeout with %0d results outstanding.", sb.awaited.size());
      $display("text_mode_console_writer_unit test failed");
      $finish;
   end

endmodule
